// ===== rtl/hufd_pkg.sv =====
// Shared types and constants for the Huffman tree bit decoder.
package hufd_pkg;

  // Default number of entries in the node table
  localparam int DEF_NODE_COUNT = 512;

  // Compressed byte width and bit counter width (holds 0..DATA_BITS)
  localparam int DATA_BITS = 8;
  localparam int TOP_BIT   = DATA_BITS - 1;
  localparam int BIT_CNT_W = $clog2(DATA_BITS + 1);

  // Field widths fixed by the stream format
  localparam int IDX_W   = 9;
  localparam int SYM_W   = 8;
  localparam int COUNT_W = 32;

  // Beat packing
  localparam int S_TDATA_W = 48;
  localparam int S_TUSER_W = 2;

  // Command codes carried on s_tuser
  localparam logic [S_TUSER_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [S_TUSER_W-1:0] CMD_DECODE  = 2'd1;
  localparam logic [S_TUSER_W-1:0] CMD_RESTART = 2'd2;

  // One node table entry
  typedef struct packed {
    logic [IDX_W-1:0] left_child;
    logic             left_valid;
    logic [IDX_W-1:0] right_child;
    logic             right_valid;
    logic [SYM_W-1:0] leaf_symbol;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Result handed to the output stage
  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] symbol;
    logic             status;
    logic             last;
  } push_t;

  // Decoder sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_WALK,
    ST_FLUSH
  } state_t;

  // A node with neither child is a leaf
  function automatic logic is_leaf(input entry_t e);
    is_leaf = !e.left_valid && !e.right_valid;
  endfunction

endpackage

// ===== rtl/hufd_ram.sv =====
// Generic single write port RAM with registered read.
module hufd_ram
  #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
  )
  (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
  );

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/hufd_out.sv =====
// Output register stage for decoded symbol beats.
module hufd_out
  import hufd_pkg::*;
  (
    input  logic             clk,
    input  logic             rst,
    input  push_t            push,
    output logic             free,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [SYM_W-1:0] m_tdata,  // symbol
    output logic             m_tuser,  // status
    output logic             m_tlast
  );

  // Slot can take a new beat when empty or being drained this cycle
  assign free = !m_tvalid || m_tready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push.valid && free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (push.valid && free) begin
      m_tdata <= push.symbol;
      m_tuser <= push.status;
      m_tlast <= push.last;
    end
  end

endmodule

// ===== rtl/huffman_tree_bit_decoder.sv =====
// Load, restart and ignored decode beats are handled in idle. A decode beat passes through
// a fetch, a walk that follows the byte bit by bit and checks each child taken for a leaf,
// and a flush; the walk ends sooner on a halt or a met count. Beats are taken one at a
// time: s_tready is high only in idle, so the next is taken after the flush. The walk does
// one dependent node table read per cycle while the output stage is free.
// Reset (synchronous, rst high): cursor, symbol count, halt flag and total_chars clear.
module huffman_tree_bit_decoder
  import hufd_pkg::*;
  #(
    parameter int NODE_COUNT = DEF_NODE_COUNT
  )
  (
    input  logic                 clk,
    input  logic                 rst,
    input  logic                 cfg_we,
    input  logic [COUNT_W-1:0]   cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // node_index, left_child, left_valid, right_child, right_valid, leaf_symbol,
    // data_byte, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,  // cmd
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [SYM_W-1:0]     m_tdata,  // symbol
    output logic                 m_tuser,  // status
    output logic                 m_tlast
  );

  localparam int IW = $clog2(NODE_COUNT);

  // Input beat fields
  logic [IDX_W-1:0] in_node_index;
  logic [IDX_W-1:0] in_left_child;
  logic             in_left_valid;
  logic [IDX_W-1:0] in_right_child;
  logic             in_right_valid;
  logic [SYM_W-1:0] in_leaf_symbol;
  logic [SYM_W-1:0] in_data_byte;

  assign in_node_index  = s_tdata[8:0];
  assign in_left_child  = s_tdata[17:9];
  assign in_left_valid  = s_tdata[18];
  assign in_right_child = s_tdata[27:19];
  assign in_right_valid = s_tdata[28];
  assign in_leaf_symbol = s_tdata[36:29];
  assign in_data_byte   = s_tdata[44:37];

  // State
  state_t                 state, state_next;
  logic [IW-1:0]          cursor, cursor_next;
  logic [COUNT_W-1:0]     count, count_next;
  logic                   halted, halted_next;
  logic [COUNT_W-1:0]     total_chars;
  logic [SYM_W-1:0]       sh, sh_next;
  logic [BIT_CNT_W-1:0]   bits, bits_next;
  logic                   pend, pend_next;
  logic [IW-1:0]          child_q, child_q_next;
  logic                   hold_v, hold_v_next;
  logic [SYM_W-1:0]       hold_sym, hold_sym_next;
  logic                   hold_err, hold_err_next;

  // Table port and output stage hookup
  logic                   ram_we;
  logic                   ram_re;
  logic [IW-1:0]          ram_raddr;
  logic [ENTRY_W-1:0]     ram_wdata;
  logic [ENTRY_W-1:0]     ram_rdata;
  entry_t                 ent_rd;
  push_t                  push;
  logic                   out_free;

  // Walk step temporaries
  logic                   take_bit;
  logic                   cur_bit;
  logic [IDX_W-1:0]       child;
  logic                   child_ok;
  logic                   new_v;
  logic [SYM_W-1:0]       new_sym;
  logic                   new_err;
  logic [COUNT_W-1:0]     count_inc;

  assign ent_rd    = entry_t'(ram_rdata);
  assign ram_wdata = {in_left_child, in_left_valid, in_right_child, in_right_valid,
                      in_leaf_symbol};
  assign count_inc = count + COUNT_W'(1);
  assign s_tready  = (state == ST_IDLE);

  hufd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NODE_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IW'(in_node_index)),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hufd_out u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Sequencer: next state, table access and result hand-off
  always_comb begin
    state_next    = state;
    cursor_next   = cursor;
    count_next    = count;
    halted_next   = halted;
    sh_next       = sh;
    bits_next     = bits;
    pend_next     = pend;
    child_q_next  = child_q;
    hold_v_next   = hold_v;
    hold_sym_next = hold_sym;
    hold_err_next = hold_err;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = cursor;
    push          = '0;
    take_bit      = 1'b0;
    cur_bit       = sh[TOP_BIT];
    child         = cur_bit ? ent_rd.right_child : ent_rd.left_child;
    child_ok      = (cur_bit ? ent_rd.right_valid : ent_rd.left_valid) &&
                    (32'(child) < 32'(NODE_COUNT));
    new_v         = 1'b0;
    new_sym       = '0;
    new_err       = 1'b0;

    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          case (s_tuser)
            CMD_LOAD: begin
              ram_we = (32'(in_node_index) < 32'(NODE_COUNT));
            end
            CMD_RESTART: begin
              cursor_next = '0;
              count_next  = '0;
              halted_next = 1'b0;
            end
            CMD_DECODE: begin
              if (!halted && (count < total_chars)) begin
                sh_next    = in_data_byte;
                bits_next  = BIT_CNT_W'(DATA_BITS);
                pend_next  = 1'b0;
                state_next = ST_FETCH;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_FETCH: begin
        ram_re     = 1'b1;
        ram_raddr  = cursor;
        state_next = ST_WALK;
      end

      ST_WALK: begin
        if (out_free) begin
          // rdata holds the child just taken: check for a leaf
          if (pend) begin
            pend_next = 1'b0;
            if (is_leaf(ent_rd)) begin
              new_v       = 1'b1;
              new_sym     = ent_rd.leaf_symbol;
              count_next  = count_inc;
              cursor_next = '0;
              ram_re      = 1'b1;
              ram_raddr   = '0;
              if ((bits == '0) || (count_inc >= total_chars)) begin
                state_next = ST_FLUSH;
              end
            end else begin
              cursor_next = child_q;
              if (bits == '0) begin
                state_next = ST_FLUSH;
              end else begin
                take_bit = 1'b1;
              end
            end
          end else begin
            take_bit = 1'b1;
          end

          // rdata holds the current node: follow the next bit
          if (take_bit) begin
            sh_next   = sh << 1;
            bits_next = bits - BIT_CNT_W'(1);
            if (!child_ok) begin
              new_v       = 1'b1;
              new_err     = 1'b1;
              halted_next = 1'b1;
              cursor_next = '0;
              state_next  = ST_FLUSH;
            end else begin
              ram_re       = 1'b1;
              ram_raddr    = IW'(child);
              child_q_next = IW'(child);
              pend_next    = 1'b1;
            end
          end
        end
      end

      ST_FLUSH: begin
        if (!hold_v) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          push        = '{valid: 1'b1, symbol: hold_sym, status: hold_err, last: 1'b1};
          hold_v_next = 1'b0;
          state_next  = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // A new result releases the held one, which is then known not to be last
    if (new_v) begin
      if (hold_v) begin
        push = '{valid: 1'b1, symbol: hold_sym, status: hold_err, last: 1'b0};
      end
      hold_v_next   = 1'b1;
      hold_sym_next = new_sym;
      hold_err_next = new_err;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cursor <= '0;
      count  <= '0;
      halted <= 1'b0;
      pend   <= 1'b0;
      hold_v <= 1'b0;
    end else begin
      state  <= state_next;
      cursor <= cursor_next;
      count  <= count_next;
      halted <= halted_next;
      pend   <= pend_next;
      hold_v <= hold_v_next;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      total_chars <= '0;
    end else if (cfg_we) begin
      total_chars <= cfg_wdata;
    end
  end

  // Bit shifter and payload registers
  always_ff @(posedge clk) begin
    sh       <= sh_next;
    bits     <= bits_next;
    child_q  <= child_q_next;
    hold_sym <= hold_sym_next;
    hold_err <= hold_err_next;
  end

`ifndef ASSERT_OFF
  // Nothing is left held once the sequencer is back at rest
  a_idle_no_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !hold_v)
    else $error("held result left behind in idle");

  // A decode beat while halted starts no walk
  a_halt_blocks: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == CMD_DECODE) && halted) |=> (state == ST_IDLE))
    else $error("decode started while halted");

  // An error beat always closes the byte and carries a zero symbol
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == '0)))
    else $error("error beat without last or with a symbol");

  // A symbol count bump only happens while walking
  a_count_walk: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count) && !$past(rst) && $past(state) != ST_IDLE) |->
      ($past(state) == ST_WALK))
    else $error("symbol count moved outside the walk");
`endif

endmodule
